### rtl/rpy_pkg.sv
// rpy_pkg: shared constants and types for the rpy mobility block pipeline
// depends on nothing; imported by rpy_pair_mobility_block

package rpy_pkg;

	// pi in q30
	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	// one in q30
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	// reciprocal of three for exact floor(x / 3) on 32-bit x, shift 33
	localparam logic [31:0] DIV3_MUL = 32'hAAAA_AAAB;
	localparam int          DIV3_SH  = 33;

	localparam int          ENT_W    = 48;
	localparam int          BR_W     = 32;

	// per-item control that travels down the pipeline
	typedef struct packed {
		logic       func;
		logic       zero;
		logic       far;
		logic [2:0] neg;   // sign of xy, xz, yz
	} side_t;

endpackage

### rtl/rpy_pair_mobility_block.sv
// rpy_pair_mobility_block: 3x3 rotne-prager-yamakawa mobility block, one item per cycle
// depends on rpy_pkg and rpy_div_pipe
// throughput: one item per cycle; busy never rises, cfg_ready always high
// the pipeline length is set by the 64-step square root, the 31-step radius divide and the
//   48-step entry divide, one bit per stage each
// reset clears the valid pipeline and sets viscosity to 1.0; no clearing pass

module rpy_pair_mobility_block
	import rpy_pkg::*;
#(
	parameter int IN_FRAC_BITS  = 16,
	parameter int OUT_FRAC_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic signed [31:0] dx,
	input  logic signed [31:0] dy,
	input  logic signed [31:0] dz,
	input  logic [30:0]        radius_first,
	input  logic [30:0]        radius_second,
	output logic               done,
	output logic signed [47:0] m_xx,
	output logic signed [47:0] m_yy,
	output logic signed [47:0] m_zz,
	output logic signed [47:0] m_xy,
	output logic signed [47:0] m_xz,
	output logic signed [47:0] m_yz,
	output logic               zero_separation,
	output logic               saturated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);

	// entry scale: bracket * 2^SHIFT_T / den, with the low 48 quotient bits divided out
	localparam int SHIFT_T = OUT_FRAC_BITS + IN_FRAC_BITS + 45;
	localparam int SH_REM  = SHIFT_T - ENT_W;

	// stage map, each number is the register stage a value sits in
	localparam int ST_SUM  = 3;
	localparam int SQ_STEPS = 64;
	localparam int ST_RS   = ST_SUM + SQ_STEPS;
	localparam int ST_L    = ST_RS + 1;
	localparam int ST_PP   = ST_L + 1;
	localparam int ST_MID  = ST_PP + 1;
	localparam int ST_DEN  = ST_MID + 1;
	localparam int UU_QW   = 31;
	localparam int ST_UU   = ST_SUM + UU_QW;
	localparam int Q_QW    = 29;
	localparam int ST_QK   = ST_SUM + Q_QW + 1;
	localparam int RHO_QW  = 31;
	localparam int ST_RHO  = ST_RS + RHO_QW;
	localparam int ST_K    = ST_RHO + 1;
	localparam int ST_PROD = ST_K + 1;
	localparam int ST_BR   = ST_PROD + 1;
	localparam int ST_DIV  = ST_BR + 1;
	localparam int ST_Q    = ST_DIV + ENT_W;
	localparam int ST_OUT  = ST_Q + 1;

	localparam logic [48:0] CAP     = 49'd1 << ENT_W;
	localparam logic [48:0] LIM_POS = (49'd1 << (ENT_W - 1)) - 49'd1;
	localparam logic [48:0] LIM_NEG = 49'd1 << (ENT_W - 1);

	// ---------------------------------------------------------------- control
	logic              accept;
	logic [ST_OUT:1]   vld_s;
	logic [31:0]       visc_q;
	logic [63:0]       pm_q;

	// the pipeline never stalls: every start is taken
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			visc_q <= 32'd65536;
		end else begin
			vld_s <= {vld_s[ST_OUT-1:1], accept};
			if (cfg_valid && cfg_ready) begin
				visc_q <= cfg_data;
			end
		end
	end

	// pi * mu, refreshed every cycle; user changes config only while idle, not enforced
	always_ff @(posedge clk) begin
		pm_q <= 64'(PI_Q30) * 64'(visc_q);
	end

	// ---------------------------------------------------------------- stage 1
	// magnitudes and signs of the separation, mean-radius sum
	logic [31:0] ax_s1 [0:2];
	logic [2:0]  neg_s1;
	logic        func_s1;
	logic [30:0] r1_s1;
	logic [31:0] a2_s1;
	logic [31:0] du [0:2];

	assign du[0] = dx;
	assign du[1] = dy;
	assign du[2] = dz;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ax_s1[i]  <= du[i][31] ? (~du[i] + 32'd1) : du[i];
			neg_s1[i] <= du[i][31];
		end
		func_s1 <= func;
		r1_s1   <= radius_first;
		a2_s1   <= {1'b0, radius_first} + {1'b0, radius_second};
	end

	// ---------------------------------------------------------------- stage 2
	// squares, cross products, (2a)^2 and the two fixed denominator lengths
	logic [63:0] pr_s2 [0:5];
	logic [63:0] a2sq_s2;
	logic [63:0] lself_s2;
	logic [63:0] lnear_s2;
	logic [33:0] twoa2_s2;
	side_t       side_s2;
	logic [32:0] r1x3;
	logic [33:0] a2x3;

	assign r1x3 = {2'b0, r1_s1} + {1'b0, r1_s1, 1'b0};
	assign a2x3 = {2'b0, a2_s1} + {1'b0, a2_s1, 1'b0};

	always_ff @(posedge clk) begin
		pr_s2[0] <= 64'(ax_s1[0]) * 64'(ax_s1[0]);
		pr_s2[1] <= 64'(ax_s1[1]) * 64'(ax_s1[1]);
		pr_s2[2] <= 64'(ax_s1[2]) * 64'(ax_s1[2]);
		pr_s2[3] <= 64'(ax_s1[0]) * 64'(ax_s1[1]);
		pr_s2[4] <= 64'(ax_s1[0]) * 64'(ax_s1[2]);
		pr_s2[5] <= 64'(ax_s1[1]) * 64'(ax_s1[2]);
		a2sq_s2  <= 64'(a2_s1) * 64'(a2_s1);
		// self: 3 * a1 * 2^30, near: 3 * 2a * 2^29
		lself_s2 <= {1'b0, r1x3, 30'b0};
		lnear_s2 <= {1'b0, a2x3, 29'b0};
		twoa2_s2 <= {1'b0, a2_s1, 1'b0};
		side_s2.func <= func_s1;
		side_s2.zero <= 1'b0;
		side_s2.far  <= 1'b0;
		side_s2.neg  <= {neg_s1[1] ^ neg_s1[2], neg_s1[0] ^ neg_s1[2], neg_s1[0] ^ neg_s1[1]};
	end

	// ---------------------------------------------------------------- stage 3
	// squared distance, zero test and far/near choice (r >= 2a)
	logic [63:0] s_sum;
	logic [63:0] s_s3;
	logic [63:0] pr_s3 [0:5];
	logic [63:0] a2sq_s3;
	side_t       side_d  [ST_SUM:ST_Q];
	logic [63:0] lself_d [ST_SUM:ST_RS];
	logic [63:0] lnear_d [ST_SUM:ST_RS];
	logic [33:0] twoa2_d [ST_SUM:ST_RS];

	assign s_sum = pr_s2[0] + pr_s2[1] + pr_s2[2];

	always_ff @(posedge clk) begin
		s_s3    <= s_sum;
		a2sq_s3 <= a2sq_s2;
		for (int i = 0; i < 6; i++) begin
			pr_s3[i] <= pr_s2[i];
		end
		side_d[ST_SUM].func <= side_s2.func;
		side_d[ST_SUM].zero <= (s_sum == 64'd0);
		side_d[ST_SUM].far  <= (s_sum >= a2sq_s2);
		side_d[ST_SUM].neg  <= side_s2.neg;
		for (int k = ST_SUM + 1; k <= ST_Q; k++) begin
			side_d[k] <= side_d[k-1];
		end
		lself_d[ST_SUM] <= lself_s2;
		lnear_d[ST_SUM] <= lnear_s2;
		twoa2_d[ST_SUM] <= twoa2_s2;
		for (int k = ST_SUM + 1; k <= ST_RS; k++) begin
			lself_d[k] <= lself_d[k-1];
			lnear_d[k] <= lnear_d[k-1];
			twoa2_d[k] <= twoa2_d[k-1];
		end
	end

	// ---------------------------------------------------------------- square root
	// rs = floor(sqrt(s * 2^64)), one result bit per stage; radicand low half is zero
	logic [66:0] sq_rem  [0:SQ_STEPS];
	logic [63:0] sq_root [0:SQ_STEPS];
	logic [63:0] sq_rad  [0:SQ_STEPS];

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = s_s3;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		logic [66:0] r;
		logic [66:0] trial;
		logic        ge;

		always_comb begin
			r     = {sq_rem[k][64:0], sq_rad[k][63:62]};
			trial = {1'b0, sq_root[k], 2'b01};
			ge    = (r >= trial);
		end

		always_ff @(posedge clk) begin
			sq_rem[k+1]  <= ge ? (r - trial) : r;
			sq_root[k+1] <= {sq_root[k][62:0], ge};
			sq_rad[k+1]  <= {sq_rad[k][61:0], 2'b00};
		end
	end

	// ---------------------------------------------------------------- unit products
	// uu = floor(|di dj| * 2^30 / s), fits 31 bits since |di dj| <= s
	logic [30:0] uu_w [0:5];
	logic [30:0] uu_d [0:5][ST_UU+1:ST_K];

	for (genvar i = 0; i < 6; i++) begin : g_uu
		rpy_div_pipe #(
			.DW (64),
			.QW (UU_QW)
		) u_div_uu (
			.clk     (clk),
			.rem_in  ({1'b0, pr_s3[i][63:1]}),
			.bits_in ({pr_s3[i][0], 30'b0}),
			.den_in  (s_s3),
			.quo_out (uu_w[i])
		);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			uu_d[i][ST_UU+1] <= uu_w[i];
			for (int k = ST_UU + 2; k <= ST_K; k++) begin
				uu_d[i][k] <= uu_d[i][k-1];
			end
		end
	end

	// ---------------------------------------------------------------- far coefficients
	// q = floor((2a)^2 * 2^28 / s), at most 2^28 in the far case
	logic [28:0] q_w;
	logic [29:0] q2;
	logic [61:0] q2div3;
	logic [30:0] kif_d [ST_QK:ST_RHO];
	logic [30:0] kdf_d [ST_QK:ST_RHO];

	rpy_div_pipe #(
		.DW (64),
		.QW (Q_QW)
	) u_div_q (
		.clk     (clk),
		.rem_in  ({1'b0, a2sq_s3[63:1]}),
		.bits_in ({a2sq_s3[0], 28'b0}),
		.den_in  (s_s3),
		.quo_out (q_w)
	);

	assign q2     = {q_w, 1'b0};
	assign q2div3 = 62'(q2) * 62'(DIV3_MUL);

	always_ff @(posedge clk) begin
		// kI = 1 + 2q/3, kD = 1 - 2q
		kif_d[ST_QK] <= ONE_Q30 + {2'b0, q2div3[61:DIV3_SH]};
		kdf_d[ST_QK] <= ONE_Q30 - {1'b0, q2};
		for (int k = ST_QK + 1; k <= ST_RHO; k++) begin
			kif_d[k] <= kif_d[k-1];
			kdf_d[k] <= kdf_d[k-1];
		end
	end

	// ---------------------------------------------------------------- near ratio
	// rho = floor(rs / (2 * 2a)), below 2^31 in the near case
	logic [63:0] rs;
	logic [30:0] rho_w;

	assign rs = sq_root[SQ_STEPS];

	rpy_div_pipe #(
		.DW (34),
		.QW (RHO_QW)
	) u_div_rho (
		.clk     (clk),
		.rem_in  ({1'b0, rs[63:31]}),
		.bits_in (rs[30:0]),
		.den_in  (twoa2_d[ST_RS]),
		.quo_out (rho_w)
	);

	// ---------------------------------------------------------------- denominator
	// den = pi * mu * L, 64x64 cut into four 32x32 partial products
	logic [63:0]  l_s68;
	logic [63:0]  pp_s69 [0:3];
	logic [63:0]  ll_s70;
	logic [63:0]  hh_s70;
	logic [64:0]  mid_s70;
	logic [127:0] den_d [ST_DEN:ST_DIV];

	always_ff @(posedge clk) begin
		if (!side_d[ST_RS].func) begin
			l_s68 <= lself_d[ST_RS];
		end else if (side_d[ST_RS].far) begin
			l_s68 <= rs;
		end else begin
			l_s68 <= lnear_d[ST_RS];
		end
		pp_s69[0] <= 64'(pm_q[31:0])  * 64'(l_s68[31:0]);
		pp_s69[1] <= 64'(pm_q[31:0])  * 64'(l_s68[63:32]);
		pp_s69[2] <= 64'(pm_q[63:32]) * 64'(l_s68[31:0]);
		pp_s69[3] <= 64'(pm_q[63:32]) * 64'(l_s68[63:32]);
		ll_s70    <= pp_s69[0];
		hh_s70    <= pp_s69[3];
		mid_s70   <= {1'b0, pp_s69[1]} + {1'b0, pp_s69[2]};
		den_d[ST_DEN] <= {hh_s70, ll_s70} + {31'b0, mid_s70, 32'b0};
		for (int k = ST_DEN + 1; k <= ST_DIV; k++) begin
			den_d[k] <= den_d[k-1];
		end
	end

	// ---------------------------------------------------------------- coefficients
	logic [34:0] rho9;
	logic [32:0] rho3;
	logic [30:0] ki_s99;
	logic [30:0] kd_s99;

	assign rho9 = {1'b0, rho_w, 3'b0} + {4'b0, rho_w};
	assign rho3 = {1'b0, rho_w, 1'b0} + {2'b0, rho_w};

	always_ff @(posedge clk) begin
		if (side_d[ST_RHO].far) begin
			ki_s99 <= kif_d[ST_RHO];
			kd_s99 <= kdf_d[ST_RHO];
		end else begin
			// near: kI = 1 - 9 rho / 32, kD = 3 rho / 32
			ki_s99 <= ONE_Q30 - {1'b0, rho9[34:5]};
			kd_s99 <= {3'b0, rho3[32:5]};
		end
	end

	// ---------------------------------------------------------------- brackets
	logic [61:0]     prod_s100 [0:5];
	logic [30:0]     ki_s100;
	logic [BR_W-1:0] br_s101 [0:5];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			prod_s100[i] <= 62'(kd_s99) * 62'(uu_d[i][ST_K]);
		end
		ki_s100 <= ki_s99;
		for (int i = 0; i < 3; i++) begin
			// diagonal: kI + kD uu, self gives plain one
			br_s101[i] <= side_d[ST_PROD].func ?
				({1'b0, ki_s100} + prod_s100[i][61:30]) : {1'b0, ONE_Q30};
			// off-diagonal magnitude, none for self
			br_s101[3+i] <= side_d[ST_PROD].func ? prod_s100[3+i][61:30] : '0;
		end
	end

	// ---------------------------------------------------------------- entry divide
	// upper quotient part tested at once: bracket * 2^SH_REM >= den means clipped
	logic [127:0] rem_w   [0:5];
	logic [127:0] rem_s102 [0:5];
	logic [11:0]  fl_d [ST_DIV:ST_Q];
	logic [11:0]  fl_w;
	logic [47:0]  quo_w [0:5];

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			rem_w[i]      = {{(128 - BR_W){1'b0}}, br_s101[i]} << SH_REM;
			fl_w[2*i]     = (br_s101[i] == '0);
			fl_w[2*i + 1] = (br_s101[i] != '0) && (rem_w[i] >= den_d[ST_BR]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			rem_s102[i] <= rem_w[i];
		end
		fl_d[ST_DIV] <= fl_w;
		for (int k = ST_DIV + 1; k <= ST_Q; k++) begin
			fl_d[k] <= fl_d[k-1];
		end
	end

	for (genvar i = 0; i < 6; i++) begin : g_ent
		rpy_div_pipe #(
			.DW (128),
			.QW (ENT_W)
		) u_div_ent (
			.clk     (clk),
			.rem_in  (rem_s102[i]),
			.bits_in ('0),
			.den_in  (den_d[ST_DIV]),
			.quo_out (quo_w[i])
		);
	end

	// ---------------------------------------------------------------- output
	// clip to the 48-bit signed range, negate off-diagonals by the sign of di dj
	function automatic logic [48:0] clip(input logic neg, input logic [48:0] m);
		logic [48:0] mag;
		logic        sat;
		sat = 1'b0;
		mag = m;
		if (!neg && m > LIM_POS) begin
			mag = LIM_POS;
			sat = 1'b1;
		end else if (neg && m > LIM_NEG) begin
			mag = LIM_NEG;
			sat = 1'b1;
		end
		if (neg) begin
			clip = {sat, 48'd0 - mag[47:0]};
		end else begin
			clip = {sat, mag[47:0]};
		end
	endfunction

	logic [48:0] mq   [0:5];
	logic [48:0] ent  [0:5];
	logic [47:0] m_q  [0:5];
	logic        zs_q;
	logic        sat_q;
	logic        sat_any;
	side_t       sd;

	always_comb begin
		sd      = side_d[ST_Q];
		sat_any = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (fl_d[ST_Q][2*i]) begin
				mq[i] = '0;
			end else if (fl_d[ST_Q][2*i + 1]) begin
				mq[i] = CAP;
			end else begin
				mq[i] = {1'b0, quo_w[i]};
			end
			ent[i]  = clip((i >= 3) ? sd.neg[i % 3] : 1'b0, mq[i]);
			sat_any = sat_any | ent[i][48];
		end
	end

	always_ff @(posedge clk) begin
		// zero separation on a pair: everything zero, flag set
		for (int i = 0; i < 6; i++) begin
			m_q[i] <= (sd.func && sd.zero) ? '0 : ent[i][47:0];
		end
		zs_q  <= sd.func && sd.zero;
		sat_q <= !(sd.func && sd.zero) && sat_any;
	end

	assign done            = vld_s[ST_OUT];
	assign m_xx            = m_q[0];
	assign m_yy            = m_q[1];
	assign m_zz            = m_q[2];
	assign m_xy            = m_q[3];
	assign m_xz            = m_q[4];
	assign m_yz            = m_q[5];
	assign zero_separation = zs_q;
	assign saturated       = sat_q;

endmodule

### rtl/rpy_div_pipe.sv
// rpy_div_pipe: restoring divider, one quotient bit per register stage
// standalone; instantiated by rpy_pair_mobility_block

module rpy_div_pipe #(
	parameter int DW = 64,
	parameter int QW = 31
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] bits_in,
	input  logic [DW-1:0] den_in,
	output logic [QW-1:0] quo_out
);

	logic [DW-1:0] rem_s  [0:QW];
	logic [DW-1:0] den_s  [0:QW];
	logic [QW-1:0] bits_s [0:QW];
	logic [QW-1:0] quo_s  [0:QW];

	assign rem_s[0]  = rem_in;
	assign den_s[0]  = den_in;
	assign bits_s[0] = bits_in;
	assign quo_s[0]  = '0;

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] sh;
		logic [DW:0] diff;
		logic        ge;

		always_comb begin
			sh   = {rem_s[k], bits_s[k][QW-1]};
			diff = sh - {1'b0, den_s[k]};
			ge   = (sh >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
			den_s[k+1]  <= den_s[k];
			bits_s[k+1] <= {bits_s[k][QW-2:0], 1'b0};
			quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
		end
	end

	assign quo_out = quo_s[QW];

endmodule

### sim/tb.sv
// tb: self-checking bench for rpy_pair_mobility_block, directed table then random pairs
// depends on rpy_pkg and the rtl of the block; results checked by an internal fixed-point predictor

module tb;
	import rpy_pkg::*;

	localparam int   LATENCY   = 151;
	localparam int   MAX_CYC   = 400000;
	localparam int   N_RANDOM  = 1020;
	localparam logic FUNC_SELF = 1'b0;
	localparam logic FUNC_PAIR = 1'b1;
	localparam int   SHIFT_OUT = 32 + 16 + 45;

	typedef struct {
		logic               func;
		logic signed [31:0] dx, dy, dz;
		logic [30:0]        r1, r2;
	} pair_item_t;

	typedef struct {
		logic [47:0] m [6];
		logic        zs;
		logic        sat;
	} mob_block_t;

	typedef struct {
		pair_item_t it;
		bit         typed;
		mob_block_t want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               func = FUNC_SELF;
	logic signed [31:0] dx = '0, dy = '0, dz = '0;
	logic [30:0]        radius_first = '0, radius_second = '0;
	logic               done;
	logic signed [47:0] m_xx, m_yy, m_zz, m_xy, m_xz, m_yz;
	logic               zero_separation, saturated;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [31:0]        cfg_data = '0;

	logic [31:0]  mu_now = 32'd65536;     // bench copy of the viscosity register
	mob_block_t   pending_blocks [$];     // blocks still owed by the pipeline
	stim_row_t    dir_rows [$];
	int           n_bad = 0;
	int           cycles = 0;
	string        ent_name [6] = '{"m_xx", "m_yy", "m_zz", "m_xy", "m_xz", "m_yz"};

	rpy_pair_mobility_block dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.dx(dx), .dy(dy), .dz(dz), .radius_first(radius_first),
		.radius_second(radius_second), .done(done), .m_xx(m_xx), .m_yy(m_yy),
		.m_zz(m_zz), .m_xy(m_xy), .m_xz(m_xz), .m_yz(m_yz),
		.zero_separation(zero_separation), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// min(floor(n * 2^k / d), cap); a zero divisor gives cap unless n is zero
	function automatic logic [63:0] scaled_quot(logic [63:0] n, int k, logic [127:0] d,
			logic [63:0] cap);
		logic [191:0] num, q;
		if (n == 0) return 64'd0;
		if (d == 0) return cap;
		num = {128'd0, n} << k;
		q = num / {64'd0, d};
		return (q > {128'd0, cap}) ? cap : q[63:0];
	endfunction

	// floor(sqrt(s * 2^64)), one bit per step
	function automatic logic [63:0] root_q32(logic [63:0] s);
		logic [127:0] target, sq;
		logic [63:0]  res, c;
		target = {s, 64'd0};
		res = '0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (64'd1 << b);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= target) res = c;
		end
		return res;
	endfunction

	// one entry: bit 48 is the clip flag, bits 47:0 the two's complement value
	function automatic logic [48:0] entry_of(bit neg, logic [63:0] br, logic [127:0] den);
		logic [63:0] m;
		bit          clip;
		m = scaled_quot(br, SHIFT_OUT, den, 64'd1 << 48);
		clip = 1'b0;
		if (!neg) begin
			if (m > (64'd1 << 47) - 1) begin
				m = (64'd1 << 47) - 1;
				clip = 1'b1;
			end
			return {clip, m[47:0]};
		end
		if (m > (64'd1 << 47)) begin
			m = 64'd1 << 47;
			clip = 1'b1;
		end
		m = -m;
		return {clip, m[47:0]};
	endfunction

	function automatic mob_block_t mobility_of(pair_item_t it, logic [31:0] mu);
		logic [63:0]  pm, s, a2, rs, q, rho, kI, kD, uu, L;
		logic [63:0]  ax [3];
		logic [63:0]  bd [3];
		logic [63:0]  bo [3];
		logic [31:0]  mag;
		logic [31:0]  v [3];
		bit           ng [3];
		logic [127:0] den;
		logic [48:0]  e;
		mob_block_t   r;
		int           pa [3] = '{0, 0, 1};
		int           pb [3] = '{1, 2, 2};
		pm = {32'd0, PI_Q30} * {32'd0, mu};
		r.zs = 1'b0;
		r.sat = 1'b0;
		for (int i = 0; i < 3; i++) ng[i] = 1'b0;
		if (it.func == FUNC_SELF) begin
			for (int i = 0; i < 3; i++) begin
				bd[i] = 64'd1 << 30;
				bo[i] = 0;
			end
			L = ({33'd0, it.r1} * 64'd3) << 30;
			den = {64'd0, pm} * {64'd0, L};
		end else begin
			v[0] = it.dx;
			v[1] = it.dy;
			v[2] = it.dz;
			s = 0;
			for (int i = 0; i < 3; i++) begin
				mag = v[i][31] ? (~v[i] + 32'd1) : v[i];
				ax[i] = {32'd0, mag};
				s = s + ax[i] * ax[i];
			end
			// zero separation: flagged, entries forced to zero
			if (s == 0) begin
				for (int i = 0; i < 6; i++) r.m[i] = '0;
				r.zs = 1'b1;
				return r;
			end
			a2 = {33'd0, it.r1} + {33'd0, it.r2};
			rs = root_q32(s);
			if (s >= a2 * a2) begin
				// far form
				q = scaled_quot(a2 * a2, 28, {64'd0, s}, 64'd1 << 40);
				kI = (64'd1 << 30) + (2 * q) / 3;
				kD = (64'd1 << 30) - 2 * q;
				den = {64'd0, pm} * {64'd0, rs};
			end else begin
				// overlapping spheres
				rho = rs / (2 * a2);
				kI = (64'd1 << 30) - (9 * rho) / 32;
				kD = (3 * rho) / 32;
				L = (64'd3 * a2) << 29;
				den = {64'd0, pm} * {64'd0, L};
			end
			for (int i = 0; i < 3; i++) begin
				uu = scaled_quot(ax[i] * ax[i], 30, {64'd0, s}, 64'd1 << 40);
				bd[i] = kI + ((kD * uu) >> 30);
				uu = scaled_quot(ax[pa[i]] * ax[pb[i]], 30, {64'd0, s}, 64'd1 << 40);
				bo[i] = (kD * uu) >> 30;
				ng[i] = v[pa[i]][31] != v[pb[i]][31];
			end
		end
		for (int i = 0; i < 3; i++) begin
			e = entry_of(1'b0, bd[i], den);
			r.m[i] = e[47:0];
			r.sat |= e[48];
			e = entry_of(ng[i], bo[i], den);
			r.m[3 + i] = e[47:0];
			r.sat |= e[48];
		end
		return r;
	endfunction

	// cycle counter doubles as the run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYC) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result check, then transfer capture, all on the rising edge
	always @(posedge clk) begin
		mob_block_t want, got;
		pair_item_t it;
		if (arst_n && done) begin
			got.m = '{m_xx, m_yy, m_zz, m_xy, m_xz, m_yz};
			got.zs = zero_separation;
			got.sat = saturated;
			if (pending_blocks.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("result with nothing outstanding at cycle %0d", cycles);
			end else begin
				want = pending_blocks.pop_front();
				for (int i = 0; i < 6; i++)
					if (got.m[i] !== want.m[i]) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%s: want %h got %h", ent_name[i], want.m[i], got.m[i]);
					end
				if (got.zs !== want.zs || got.sat !== want.sat) begin
					n_bad++;
					if (n_bad <= 10)
						$display("flags zs/sat: want %b%b got %b%b", want.zs, want.sat,
							got.zs, got.sat);
				end
			end
		end
		if (arst_n && start && !busy) begin
			it.func = func;
			it.dx = dx;
			it.dy = dy;
			it.dz = dz;
			it.r1 = radius_first;
			it.r2 = radius_second;
			if (dir_rows.size() > 0 && dir_rows[0].it == it && dir_rows[0].typed)
				pending_blocks.push_back(dir_rows[0].want);
			else
				pending_blocks.push_back(mobility_of(it, mu_now));
			if (dir_rows.size() > 0) void'(dir_rows.pop_front());
		end
		if (arst_n && cfg_valid && cfg_ready) mu_now <= cfg_data;
	end

	// keeps start high across a burst, drops it only for a gap
	task automatic send_item(pair_item_t it, int gap);
		@(negedge clk);
		start <= 1'b1;
		func <= it.func;
		dx <= it.dx;
		dy <= it.dy;
		dz <= it.dz;
		radius_first <= it.r1;
		radius_second <= it.r2;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// register write only once the pipeline has drained
	task automatic write_mu(logic [31:0] val);
		@(negedge clk);
		start <= 1'b0;
		wait (pending_blocks.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic pair_item_t mk(logic f, int x, int y, int z, int a, int b);
		pair_item_t it;
		it.func = f;
		it.dx = x;
		it.dy = y;
		it.dz = z;
		it.r1 = a[30:0];
		it.r2 = b[30:0];
		return it;
	endfunction

	function automatic stim_row_t row(pair_item_t it);
		stim_row_t r;
		r.it = it;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic pair_item_t rand_item();
		pair_item_t it;
		int         roll;
		roll = $urandom_range(0, 99);
		it.func = (roll < 15) ? FUNC_SELF : FUNC_PAIR;
		it.dx = $signed($urandom) >>> $urandom_range(0, 31);
		it.dy = $signed($urandom) >>> $urandom_range(0, 31);
		it.dz = $signed($urandom) >>> $urandom_range(0, 31);
		it.r1 = 31'($urandom >> $urandom_range(1, 31));
		it.r2 = 31'($urandom >> $urandom_range(1, 31));
		// scale radii to the separation so both forms are common
		if (roll >= 15 && roll < 60) begin
			it.r1 = 31'($urandom >> $urandom_range(1, 3));
			it.r2 = it.r1 ^ 31'($urandom_range(0, 65535));
		end
		if (roll >= 98) begin
			it.dx = '0;
			it.dy = '0;
			it.dz = '0;
		end
		return it;
	endfunction

	initial begin
		stim_row_t  r;
		stim_row_t  rows [$];
		pair_item_t it;
		int         burst;
		int         n_sent;
		logic [31:0] mu_set [4];

		// zero separation and a self item with zero radius read straight off the spec
		r = row(mk(FUNC_PAIR, 0, 0, 0, 65536, 65536));
		r.typed = 1'b1;
		r.want.m = '{default: '0};
		r.want.zs = 1'b1;
		r.want.sat = 1'b0;
		rows.push_back(r);
		r = row(mk(FUNC_SELF, 0, 0, 0, 0, 0));
		r.typed = 1'b1;
		r.want.m = '{48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 0, 0, 0};
		r.want.zs = 1'b0;
		r.want.sat = 1'b1;
		rows.push_back(r);
		// self with extreme radii, ignored second radius
		rows.push_back(row(mk(FUNC_SELF, -1, 7, 3, 1, 0)));
		rows.push_back(row(mk(FUNC_SELF, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF)));
		rows.push_back(row(mk(FUNC_SELF, 5, 5, 5, 65536, 12345)));
		// far form, axis and diagonal separations with mixed signs
		rows.push_back(row(mk(FUNC_PAIR, 10 << 16, 0, 0, 65536, 65536)));
		rows.push_back(row(mk(FUNC_PAIR, -(3 << 16), 4 << 16, -(5 << 16), 65536, 32768)));
		rows.push_back(row(mk(FUNC_PAIR, 1 << 16, -(1 << 16), 1 << 16, 1, 1)));
		// exactly touching spheres: r equal to 2a
		rows.push_back(row(mk(FUNC_PAIR, 2 << 16, 0, 0, 65536, 65536)));
		// overlapping spheres, both signs
		rows.push_back(row(mk(FUNC_PAIR, 1 << 15, 1 << 14, -(1 << 14), 65536, 65536)));
		rows.push_back(row(mk(FUNC_PAIR, -1, -1, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF)));
		// both radii zero take the far form
		rows.push_back(row(mk(FUNC_PAIR, 3, -4, 0, 0, 0)));
		// field extremes
		rows.push_back(row(mk(FUNC_PAIR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1)));
		rows.push_back(row(mk(FUNC_PAIR, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 1)));
		rows.push_back(row(mk(FUNC_PAIR, 1, 0, 0, 1, 1)));
		rows.push_back(row(mk(FUNC_PAIR, 0, 0, -1, 32'h7FFF_FFFF, 0)));
		rows.push_back(row(mk(FUNC_PAIR, 0, 32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFF)));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, back to back with a gap after every fifth row
		foreach (rows[i]) dir_rows.push_back(rows[i]);
		foreach (rows[i]) send_item(rows[i].it, (i % 5 == 4) ? 2 : 0);

		// viscosity phases: extremes first, then 1.0 and a random mid value
		mu_set = '{32'd1, 32'hFFFF_FFFF, 32'd65536, $urandom_range(32'h8000, 32'h40_0000)};
		n_sent = 0;
		foreach (mu_set[p]) begin
			write_mu(mu_set[p]);
			// repeat a few directed rows under the new setting
			for (int i = 2; i < 8; i++) send_item(rows[i].it, 0);
			while (n_sent < (p + 1) * N_RANDOM / 4) begin
				burst = $urandom_range(1, 24);
				for (int j = 0; j < burst; j++) begin
					it = rand_item();
					if (p == 2 || j < burst - 1) send_item(it, 0);
					else send_item(it, $urandom_range(1, 9));
					n_sent++;
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		wait (pending_blocks.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		if (n_bad == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
